// ----- src/smix_pkg.sv -----
package smix_pkg;

    localparam int DATA_W          = 32;
    localparam int LANES           = 8;
    localparam int MAX_SOURCES_DEF = 8;
    localparam int SUM_W           = DATA_W + $clog2(LANES);
    localparam int CNT_W           = 4;
    localparam int FMT_W           = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 4;

    typedef enum logic [FMT_W-1:0] {
        FMT_S16 = 2'd0,
        FMT_S24 = 2'd1,
        FMT_S32 = 2'd2
    } fmt_t;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;

    localparam fmt_t             FORMAT_RST = FMT_S16;
    localparam logic [CNT_W-1:0] COUNT_RST  = 4'd2;

    localparam logic signed [SUM_W-1:0] S16_MIN = SUM_W'(-32768);
    localparam logic signed [SUM_W-1:0] S16_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] S24_MIN = SUM_W'(-8388608);
    localparam logic signed [SUM_W-1:0] S24_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-64'sd2147483648);
    localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_0;
        logic signed [DATA_W-1:0] sample_1;
        logic signed [DATA_W-1:0] sample_2;
        logic signed [DATA_W-1:0] sample_3;
        logic signed [DATA_W-1:0] sample_4;
        logic signed [DATA_W-1:0] sample_5;
        logic signed [DATA_W-1:0] sample_6;
        logic signed [DATA_W-1:0] sample_7;
        logic                     block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] mixed_sample;
        logic                     block_end_out;
    } out_item_t;

    // Payload handed from cell to cell: running sum plus the raw lanes.
    typedef struct packed {
        logic signed [SUM_W-1:0]         sum;
        logic [LANES-1:0][DATA_W-1:0]    samples;
        logic                            block_end;
    } stage_t;

    // Sign-extend one container according to the sample format.
    function automatic logic signed [SUM_W-1:0] sext_sample(
        input logic [DATA_W-1:0] s,
        input fmt_t              fmt
    );
        logic signed [SUM_W-1:0] r;
        unique case (fmt)
            FMT_S16: r = SUM_W'($signed(s[15:0]));
            FMT_S24: r = SUM_W'($signed(s[23:0]));
            default: r = SUM_W'($signed(s));
        endcase
        return r;
    endfunction

endpackage

// ----- src/smix_cell.sv -----
module smix_cell #(
    parameter int LANE = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  smix_pkg::fmt_t          fmt,
    input  logic [smix_pkg::CNT_W-1:0] count,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  smix_pkg::stage_t        in_stage,
    output logic                    out_valid,
    input  logic                    out_ready,
    output smix_pkg::stage_t        out_stage
);
    import smix_pkg::*;

    localparam logic [CNT_W-1:0] LANE_IDX = CNT_W'(LANE);

    logic   valid_reg, valid_next;
    stage_t stage_reg, stage_next;
    logic   lane_used;

    assign lane_used = (count > LANE_IDX);
    assign in_ready  = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        stage_next = stage_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            stage_next = in_stage;
            if (lane_used) begin
                stage_next.sum = in_stage.sum + sext_sample(in_stage.samples[LANE], fmt);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ----- src/smix_sat.sv -----
module smix_sat (
    input  logic                aclk,
    input  logic                aresetn,
    input  smix_pkg::fmt_t      fmt,
    input  logic                in_valid,
    output logic                in_ready,
    input  smix_pkg::stage_t    in_stage,
    output logic                m_valid,
    input  logic                m_ready,
    output smix_pkg::out_item_t m_item
);
    import smix_pkg::*;

    logic                    valid_reg, valid_next;
    out_item_t               item_reg, item_next;
    fmt_t                    fmt_reg, fmt_next;
    logic signed [SUM_W-1:0] lo, hi, clamped;

    always_comb begin
        unique case (fmt)
            FMT_S16: begin
                lo = S16_MIN;
                hi = S16_MAX;
            end
            FMT_S24: begin
                lo = S24_MIN;
                hi = S24_MAX;
            end
            default: begin
                lo = S32_MIN;
                hi = S32_MAX;
            end
        endcase
        priority if (in_stage.sum < lo) begin
            clamped = lo;
        end else if (in_stage.sum > hi) begin
            clamped = hi;
        end else begin
            clamped = in_stage.sum;
        end
    end

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        fmt_next   = fmt_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            item_next.mixed_sample  = clamped[DATA_W-1:0];
            item_next.block_end_out = in_stage.block_end;
            fmt_next                = fmt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
        fmt_reg  <= fmt_next;
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    // Narrow formats must come out sign-extended from their own width
    a_s16_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (fmt_reg == FMT_S16) |->
            (item_reg.mixed_sample[31:15] == '0) || (item_reg.mixed_sample[31:15] == '1))
        else $error("s16 result out of range");

    a_s24_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (fmt_reg == FMT_S24) |->
            (item_reg.mixed_sample[31:23] == '0) || (item_reg.mixed_sample[31:23] == '1))
        else $error("s24 result out of range");

endmodule

// ----- src/saturating_pcm_mixer.sv -----
// Channel   Dir  Handshake             Payload
// s_        in   s_valid / s_ready     s_item   (smix_pkg::in_item_t)
// m_        out  m_valid / m_ready     m_item   (smix_pkg::out_item_t)
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle sustained while m_ready stays high; the path is
// one adder cell per source lane, then the clamp/output register.
// Each cell and the output stage hold one transaction, so the chain stalls
// stage by stage from the output back; s_ready drops only when every stage
// is full and m_ready is low.
// aresetn (sync, active low) empties the chain and restores format s16,
// source count 2. cfg_ready is always high.
module saturating_pcm_mixer #(
    parameter int MAX_SOURCES = smix_pkg::MAX_SOURCES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  smix_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output smix_pkg::out_item_t            m_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smix_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smix_pkg::CFG_DATA_W-1:0] cfg_data
);
    import smix_pkg::*;

    // Configuration registers
    fmt_t             fmt_reg, fmt_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        fmt_next   = fmt_reg;
        count_next = count_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FORMAT: fmt_next   = fmt_t'(cfg_data[FMT_W-1:0]);
                REG_COUNT:  count_next = cfg_data[CNT_W-1:0];
                default: ;  // unmapped index: write ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= FORMAT_RST;
            count_reg <= COUNT_RST;
        end else begin
            fmt_reg   <= fmt_next;
            count_reg <= count_next;
        end
    end

    // Cell chain: link k feeds cell k, link MAX_SOURCES feeds the clamp stage
    stage_t chain_stage [MAX_SOURCES+1];
    logic   chain_valid [MAX_SOURCES+1];
    logic   chain_ready [MAX_SOURCES+1];

    // Entry: zero sum, lanes unpacked from the input struct
    always_comb begin
        chain_stage[0].sum        = '0;
        chain_stage[0].samples[0] = s_item.sample_0;
        chain_stage[0].samples[1] = s_item.sample_1;
        chain_stage[0].samples[2] = s_item.sample_2;
        chain_stage[0].samples[3] = s_item.sample_3;
        chain_stage[0].samples[4] = s_item.sample_4;
        chain_stage[0].samples[5] = s_item.sample_5;
        chain_stage[0].samples[6] = s_item.sample_6;
        chain_stage[0].samples[7] = s_item.sample_7;
        chain_stage[0].block_end  = s_item.block_end;
    end

    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];

    // A count above MAX_SOURCES simply runs out of cells
    for (genvar k = 0; k < MAX_SOURCES; k++) begin : g_cell
        smix_cell #(
            .LANE(k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .fmt       (fmt_reg),
            .count     (count_reg),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_stage  (chain_stage[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_stage (chain_stage[k+1])
        );
    end

    smix_sat u_sat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fmt      (fmt_reg),
        .in_valid (chain_valid[MAX_SOURCES]),
        .in_ready (chain_ready[MAX_SOURCES]),
        .in_stage (chain_stage[MAX_SOURCES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // Backpressure only originates at the output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // Check that the first link fills after a transaction is taken at the input.
    a_first_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> chain_valid[1])
        else $error("accepted transaction lost in first cell");

endmodule

// ----- verif/pcm_mix_checker.sv -----
`timescale 1ns / 100ps

module pcm_mix_checker #(
    parameter int MAX_SOURCES = smix_pkg::MAX_SOURCES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  smix_pkg::in_item_t              s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  smix_pkg::out_item_t             m_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [smix_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smix_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              results_seen,
    output int                              backlog,
    output int                              clipped_high,
    output int                              clipped_low
);
    import smix_pkg::*;

    logic [FMT_W-1:0] mix_fmt;
    logic [CNT_W-1:0] mix_cnt;
    out_item_t        mixed_q[$];

    // Expected mixer output; rail reports +1 / -1 when the sum hit a clamp.
    function automatic out_item_t mix_lanes(
        input  in_item_t         it,
        input  logic [FMT_W-1:0] fmt,
        input  logic [CNT_W-1:0] cnt,
        output int               rail
    );
        logic [DATA_W-1:0]  lane [LANES];
        logic signed [63:0] acc;
        logic signed [63:0] term;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        int                 used;
        int                 i;
        out_item_t          r;
        lane[0] = it.sample_0;
        lane[1] = it.sample_1;
        lane[2] = it.sample_2;
        lane[3] = it.sample_3;
        lane[4] = it.sample_4;
        lane[5] = it.sample_5;
        lane[6] = it.sample_6;
        lane[7] = it.sample_7;
        used = (int'(cnt) > MAX_SOURCES) ? MAX_SOURCES : int'(cnt);
        if (used > LANES) used = LANES;
        case (fmt)
            FMT_S16: begin
                lo = -64'sd32768;
                hi = 64'sd32767;
            end
            FMT_S24: begin
                lo = -64'sd8388608;
                hi = 64'sd8388607;
            end
            default: begin
                // reserved code 3 runs as 32-bit
                lo = -64'sd2147483648;
                hi = 64'sd2147483647;
            end
        endcase
        acc = '0;
        for (i = 0; i < used; i++) begin
            case (fmt)
                FMT_S16: term = $signed(lane[i][15:0]);
                FMT_S24: term = $signed(lane[i][23:0]);
                default: term = $signed(lane[i]);
            endcase
            acc = acc + term;
        end
        rail = 0;
        if (acc > hi) begin
            acc  = hi;
            rail = 1;
        end else if (acc < lo) begin
            acc  = lo;
            rail = -1;
        end
        r.mixed_sample  = acc[DATA_W-1:0];
        r.block_end_out = it.block_end;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        int        rail;
        if (!aresetn) begin
            mix_fmt = FORMAT_RST;
            mix_cnt = COUNT_RST;
            mixed_q.delete();
            backlog      = 0;
            mismatches   = 0;
            clipped_high = 0;
            clipped_low  = 0;
            results_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (mixed_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h / %b",
                             $time, m_item.mixed_sample, m_item.block_end_out);
                end else begin
                    want = mixed_q.pop_front();
                    if (m_item.mixed_sample !== want.mixed_sample) begin
                        mismatches++;
                        $display("%0t: mixed_sample expected %h, got %h",
                                 $time, want.mixed_sample, m_item.mixed_sample);
                    end
                    if (m_item.block_end_out !== want.block_end_out) begin
                        mismatches++;
                        $display("%0t: block_end_out expected %b, got %b",
                                 $time, want.block_end_out, m_item.block_end_out);
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (s_valid && s_ready) begin
                mixed_q.push_back(mix_lanes(s_item, mix_fmt, mix_cnt, rail));
                if (rail > 0) clipped_high++;
                if (rail < 0) clipped_low++;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FORMAT)
                    mix_fmt = cfg_data[FMT_W-1:0];
                else if (cfg_index == REG_COUNT)
                    mix_cnt = cfg_data[CNT_W-1:0];
            end
            backlog = mixed_q.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import smix_pkg::*;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd2;
    // Format code with no format of its own; the mixer treats it as s32.
    localparam logic [FMT_W-1:0]     FMT_RESERVED = 2'd3;

    localparam int  RAND_PHASES = 13;
    localparam int  PHASE_ITEMS = 72;
    localparam int  HOLD_CYCLES = 150;           // long sink stall, fills the chain
    localparam int  DRAIN_CYCLES = 2 * MAX_SOURCES_DEF + 4;
    localparam real TIMEOUT_NS  = 5_000_000.0;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int results_seen;
    int backlog;
    int clipped_high;
    int clipped_low;

    int items_sent    = 0;
    int settings_used = 1;          // reset values count as the first setting

    // Idle switches for the two sides; the sink stall is a one-shot request.
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;

    saturating_pcm_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcm_mix_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .backlog      (backlog),
        .clipped_high (clipped_high),
        .clipped_low  (clipped_low)
    );

    always #6 aclk = ~aclk;

    // Lane 0 gets a, all higher lanes get b. Handy for "only the first lanes
    // count" cases and for uniform full-scale vectors.
    function automatic in_item_t lane_item(input logic [31:0] a, input logic [31:0] b,
                                           input logic be);
        in_item_t it;
        it.sample_0  = a;
        it.sample_1  = b;
        it.sample_2  = b;
        it.sample_3  = b;
        it.sample_4  = b;
        it.sample_5  = b;
        it.sample_6  = b;
        it.sample_7  = b;
        it.block_end = be;
        return it;
    endfunction

    // One sample biased toward the rails of the active format. Bits above the
    // format width are filled with junk, which the mixer has to ignore.
    function automatic logic [31:0] pick_sample(input logic [FMT_W-1:0] fmt);
        int unsigned w;
        logic [31:0] full;
        logic [31:0] junk;
        w    = (fmt == FMT_S16) ? 16 : (fmt == FMT_S24) ? 24 : 32;
        junk = $urandom;
        case ($urandom_range(0, 4))
            0: full = $urandom;
            1: full = (32'h1 << (w - 1)) - 32'h1;          // positive full scale
            2: full = -(32'h1 << (w - 1));                 // negative full scale
            3: full = 32'($urandom_range(0, 511)) - 32'd256;
            default: begin
                full = (32'h1 << (w - 2)) + 32'($urandom_range(0, 4095));
                if ($urandom_range(0, 1) == 1) full = -full;
            end
        endcase
        if (w < 32) full = (junk << w) | (full & ((32'h1 << w) - 32'h1));
        return full;
    endfunction

    function automatic in_item_t rand_item(input logic [FMT_W-1:0] fmt);
        in_item_t it;
        it.sample_0  = pick_sample(fmt);
        it.sample_1  = pick_sample(fmt);
        it.sample_2  = pick_sample(fmt);
        it.sample_3  = pick_sample(fmt);
        it.sample_4  = pick_sample(fmt);
        it.sample_5  = pick_sample(fmt);
        it.sample_6  = pick_sample(fmt);
        it.sample_7  = pick_sample(fmt);
        it.block_end = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // Offer one transaction, maybe after an idle burst. Returns on the edge
    // that accepts it with s_valid still high, so back-to-back items stream.
    task automatic send_item(input in_item_t it);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Leaves cfg_valid high; configure() drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Registers only change with the chain empty: every item gives exactly
    // one result, so matching counts means nothing is in flight.
    task automatic configure(input logic [CFG_DATA_W-1:0] fmt_word,
                             input logic [CFG_DATA_W-1:0] cnt_word,
                             input bit poke_spare);
        s_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge aclk);
        if (poke_spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(REG_FORMAT, fmt_word);
        write_reg(REG_COUNT, cnt_word);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sink side: ready most of the time, idle bursts, and one long stall on
    // request. Each pass makes a single assignment to m_ready.
    initial begin : sink
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [FMT_W-1:0] fmt;
        logic [CNT_W-1:0] cnt;
        int               phase;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setting, s16 with two sources: silence, both rails, rails
        // cancelling, and junk in the upper half of each container.
        send_item(lane_item(32'h0000_0000, 32'h0000_0000, 1'b0));
        send_item(lane_item(32'h0000_7FFF, 32'h0000_7FFF, 1'b1));
        send_item(lane_item(32'hFFFF_8000, 32'hFFFF_8000, 1'b0));
        send_item(lane_item(32'h0000_7FFF, 32'hFFFF_8000, 1'b1));
        send_item(lane_item(32'hABCD_1234, 32'h5A5A_0001, 1'b0));

        // s24, all eight lanes: top byte ignored, clamp at 24 bits.
        configure({2'b00, FMT_S24}, 4'd8, 1'b0);
        send_item(lane_item(32'h007F_FFFF, 32'h007F_FFFF, 1'b0));
        send_item(lane_item(32'hFF80_0000, 32'hFF80_0000, 1'b1));
        send_item(lane_item(32'h127F_FFFF, 32'hEE80_0001, 1'b0));

        // s32, all eight lanes: wide sum must not wrap.
        configure({2'b00, FMT_S32}, 4'd8, 1'b0);
        send_item(lane_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_item(lane_item(32'h8000_0000, 32'h8000_0000, 1'b1));
        send_item(lane_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_item(lane_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));

        // No sources at all, and a write to the unmapped index on the way.
        configure({2'b00, FMT_S32}, 4'd0, 1'b1);
        send_item(rand_item(FMT_S32));
        send_item(lane_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));

        // Count above the lane limit sums only the available lanes.
        configure({2'b00, FMT_S16}, 4'd15, 1'b0);
        send_item(lane_item(32'h0000_7FFF, 32'h0000_7FFF, 1'b0));
        send_item(lane_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));

        // One source; upper lanes at full scale must not leak in. High bits
        // of the format write are set and must be dropped.
        configure({2'b11, FMT_S24}, 4'd1, 1'b0);
        send_item(lane_item(32'h0000_0005, 32'h007F_FFFF, 1'b0));
        send_item(lane_item(32'h0080_0000, 32'h007F_FFFF, 1'b1));

        // Reserved format code behaves as s32.
        configure({2'b00, FMT_RESERVED}, 4'd2, 1'b0);
        send_item(lane_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_item(lane_item(32'h0000_8000, 32'h0000_8000, 1'b1));

        // Random phases, each under a fresh setting. Counts stay mostly in
        // the useful 1..8 range; the last phase runs with no idling at all.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == RAND_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            fmt = FMT_W'($urandom_range(0, 3));
            cnt = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 15))
                                              : CNT_W'($urandom_range(1, 8));
            configure({2'($urandom_range(0, 3)), fmt}, cnt, phase == 5);
            if (phase == 3) begin
                // Sink stalls long while the source keeps streaming, so the
                // chain fills and s_ready has to drop.
                hold_request = 1'b1;
                tx_idle_on   = 1'b0;
            end
            repeat (PHASE_ITEMS) send_item(rand_item(fmt));
            if (phase == 3) tx_idle_on = 1'b1;
        end

        s_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge aclk);
        // Extra cycles past the pipeline depth to catch any stray output.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d mixed samples under %0d register settings",
                 results_seen, settings_used);
        $display("clamped at positive rail %0d times, at negative rail %0d times",
                 clipped_high, clipped_low);
        if (mismatches == 0 && backlog == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- saturating_pcm_mixer.f -----
src/smix_pkg.sv
src/smix_cell.sv
src/smix_sat.sv
src/saturating_pcm_mixer.sv
verif/pcm_mix_checker.sv
verif/testbench.sv
